>>> design/lgb_pkg.sv
`timescale 1ns / 1ps

package lgb_pkg;

   // Raster geometry
   localparam int unsigned BEAM_W = 19;
   localparam int unsigned VCNT_W = 9;
   localparam int unsigned HCNT_W = 11;
   localparam logic [HCNT_W-1:0] LINE_CLOCKS = 11'd1364;

   // Cursor and register widths
   localparam int unsigned AIM_W = 10;
   localparam int unsigned VIS_W = 8;
   localparam logic [VIS_W-1:0] VISIBLE_RESET = 8'd224;

   // Serial report slots
   localparam int unsigned CNT_W = 4;
   localparam logic [CNT_W-1:0] SLOT_TRIGGER   = 4'd0;
   localparam logic [CNT_W-1:0] SLOT_CURSOR    = 4'd1;
   localparam logic [CNT_W-1:0] SLOT_TURBO     = 4'd2;
   localparam logic [CNT_W-1:0] SLOT_PAUSE     = 4'd3;
   localparam logic [CNT_W-1:0] SLOT_OFFSCREEN = 4'd6;
   localparam logic [CNT_W-1:0] SLOT_DONE      = 4'd8;

   // CSR map
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic CSR_SEL_VISIBLE = 1'b0;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_LATCH = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef struct packed {
      logic                    strobe;
      logic                    wrap;
      logic signed [AIM_W-1:0] col_wrap;
      logic signed [AIM_W-1:0] row_wrap;
      logic                    off_wrap;
      logic                    off_now;
   } beam_result_type;

endpackage

>>> design/lgb_beam.sv
`timescale 1ns / 1ps

module lgb_beam (
   input  logic [lgb_pkg::BEAM_W-1:0]       beam_pos,
   input  logic [lgb_pkg::BEAM_W-1:0]       last_pos,
   input  logic signed [lgb_pkg::AIM_W-1:0] aim_col,
   input  logic signed [lgb_pkg::AIM_W-1:0] aim_row,
   input  logic                             off_screen,
   input  logic signed [lgb_pkg::AIM_W-1:0] delta_x,
   input  logic signed [lgb_pkg::AIM_W-1:0] delta_y,
   input  logic [lgb_pkg::VIS_W-1:0]        visible_lines,
   output lgb_pkg::beam_result_type         result
);

   localparam logic signed [10:0] AIM_MIN = -11'sd16;
   localparam logic signed [10:0] COL_MAX = 11'sd272;
   localparam logic signed [10:0] ROW_MAX = 11'sd256;
   localparam logic signed [10:0] COL_EDGE = 11'sd256;
   localparam logic signed [20:0] COL_BIAS = 21'sd24;

   logic signed [20:0] row_term;
   logic signed [20:0] col_term;
   logic signed [20:0] target;
   logic signed [20:0] next_s;
   logic signed [20:0] last_s;
   logic signed [10:0] sum_x;
   logic signed [10:0] sum_y;
   logic signed [10:0] col_c;
   logic signed [10:0] row_c;
   logic signed [10:0] vis_s;

   function automatic logic off_test(input logic signed [10:0] col,
                                     input logic signed [10:0] row,
                                     input logic signed [10:0] vis);
      off_test = (col < 11'sd0) || (row < 11'sd0) || (col >= COL_EDGE) || (row >= vis);
   endfunction

   always_comb begin
      // Target lies four master clocks per dot, offset by the left border
      row_term = 21'(aim_row) * $signed({10'd0, lgb_pkg::LINE_CLOCKS});
      col_term = (21'(aim_col) + COL_BIAS) <<< 2;
      target   = row_term + col_term;
      next_s   = $signed({2'b00, beam_pos});
      last_s   = $signed({2'b00, last_pos});

      sum_x = 11'(delta_x) + 11'(aim_col);
      sum_y = 11'(delta_y) + 11'(aim_row);
      col_c = (sum_x < AIM_MIN) ? AIM_MIN : ((sum_x > COL_MAX) ? COL_MAX : sum_x);
      row_c = (sum_y < AIM_MIN) ? AIM_MIN : ((sum_y > ROW_MAX) ? ROW_MAX : sum_y);
      vis_s = $signed({3'b000, visible_lines});

      result.strobe   = !off_screen && (next_s >= target) && (last_s < target);
      result.wrap     = beam_pos < last_pos;
      result.col_wrap = col_c[lgb_pkg::AIM_W-1:0];
      result.row_wrap = row_c[lgb_pkg::AIM_W-1:0];
      result.off_wrap = off_test(col_c, row_c, vis_s);
      result.off_now  = off_test(11'(aim_col), 11'(aim_row), vis_s);
   end

endmodule

>>> design/light_gun_beam_and_serial_port_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req_*     in         req_valid/req_stall  op, raster counters, deltas, latch, buttons
// rsp_*     out        rsp_valid/rsp_stall  strobe, serial bit, aim x/y, turbo state
// csr_*     in/out     psel/penable/pready  visible_lines at byte address 0
//
// Each transaction is registered in the input register (beam position multiply),
// then passes through the beam and serial logic into the result register. A new
// transaction is taken every cycle unless req_stall is high.
// Reset is synchronous and clears all control state; visible_lines returns to 224.
// A stalled result holds in the result register while the input register
// still takes one more transaction; req_stall rises only when both are full.

module light_gun_beam_and_serial_port_core (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_op,
   input  logic [lgb_pkg::VCNT_W-1:0]           req_vcounter_in,
   input  logic [lgb_pkg::HCNT_W-1:0]           req_hcounter_in,
   input  logic signed [lgb_pkg::AIM_W-1:0]     req_delta_x,
   input  logic signed [lgb_pkg::AIM_W-1:0]     req_delta_y,
   input  logic                                 req_latch_level,
   input  logic                                 req_trigger_button,
   input  logic                                 req_cursor_button,
   input  logic                                 req_turbo_switch,
   input  logic                                 req_pause_button,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_latch_strobe,
   output logic                                 rsp_serial_bit,
   output logic signed [lgb_pkg::AIM_W-1:0]     rsp_aim_x,
   output logic signed [lgb_pkg::AIM_W-1:0]     rsp_aim_y,
   output logic                                 rsp_turbo_active,

   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lgb_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

   // ---------------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------------
   logic [lgb_pkg::VIS_W-1:0] visible_lines_ff;
   logic [lgb_pkg::VIS_W-1:0] visible_lines_in;
   logic                      csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == lgb_pkg::CSR_SEL_VISIBLE);

   always_comb begin
      visible_lines_in = visible_lines_ff;
      if (csr_write) begin
         visible_lines_in = csr_pwdata[lgb_pkg::VIS_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == lgb_pkg::CSR_SEL_VISIBLE) begin
         csr_prdata = {24'd0, visible_lines_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visible_lines_ff <= lgb_pkg::VISIBLE_RESET;
      end else begin
         visible_lines_ff <= visible_lines_in;
      end
   end

   // ---------------------------------------------------------------------
   // Handshake: input register feeds result register
   // ---------------------------------------------------------------------
   logic s1_valid_ff;
   logic s1_valid_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic advance;
   logic take;

   // The result register frees up when empty or when its transaction leaves
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // Input register: beam position is formed here
   // ---------------------------------------------------------------------
   logic [1:0]                        s1_op_ff;
   logic [lgb_pkg::BEAM_W-1:0]        s1_beam_ff;
   logic signed [lgb_pkg::AIM_W-1:0]  s1_dx_ff;
   logic signed [lgb_pkg::AIM_W-1:0]  s1_dy_ff;
   logic                              s1_latch_ff;
   logic                              s1_trigger_ff;
   logic                              s1_cursor_ff;
   logic                              s1_turbo_ff;
   logic                              s1_pause_ff;
   logic [20:0]                       beam_full;

   // Out of range counters simply wrap into 19 bits
   assign beam_full = 21'(req_vcounter_in) * 21'(lgb_pkg::LINE_CLOCKS) +
                      21'(req_hcounter_in);

   always_ff @(posedge clock) begin
      if (take) begin
         s1_op_ff      <= req_op;
         s1_beam_ff    <= beam_full[lgb_pkg::BEAM_W-1:0];
         s1_dx_ff      <= req_delta_x;
         s1_dy_ff      <= req_delta_y;
         s1_latch_ff   <= req_latch_level;
         s1_trigger_ff <= req_trigger_button;
         s1_cursor_ff  <= req_cursor_button;
         s1_turbo_ff   <= req_turbo_switch;
         s1_pause_ff   <= req_pause_button;
      end
   end

   // ---------------------------------------------------------------------
   // Controller state
   // ---------------------------------------------------------------------
   logic [lgb_pkg::BEAM_W-1:0]        last_beam_ff,   last_beam_in;
   logic signed [lgb_pkg::AIM_W-1:0]  aim_col_ff,     aim_col_in;
   logic signed [lgb_pkg::AIM_W-1:0]  aim_row_ff,     aim_row_in;
   logic                              off_screen_ff,  off_screen_in;
   logic                              latch_seen_ff,  latch_seen_in;
   logic [lgb_pkg::CNT_W-1:0]         bit_counter_ff, bit_counter_in;
   logic                              turbo_prev_ff,  turbo_prev_in;
   logic                              turbo_toggle_ff, turbo_toggle_in;
   logic                              trigger_hold_ff, trigger_hold_in;
   logic                              trigger_bit_ff, trigger_bit_in;
   logic                              pause_hold_ff,  pause_hold_in;
   logic                              pause_bit_ff,   pause_bit_in;
   logic                              cursor_bit_ff,  cursor_bit_in;

   logic                              strobe;
   logic                              serial;
   lgb_pkg::beam_result_type          beam_res;
   lgb_pkg::op_type                   op;

   assign op = lgb_pkg::op_type'(s1_op_ff);

   lgb_beam u_beam (
      .beam_pos      (s1_beam_ff),
      .last_pos      (last_beam_ff),
      .aim_col       (aim_col_ff),
      .aim_row       (aim_row_ff),
      .off_screen    (off_screen_ff),
      .delta_x       (s1_dx_ff),
      .delta_y       (s1_dy_ff),
      .visible_lines (visible_lines_ff),
      .result        (beam_res)
   );

   always_comb begin
      last_beam_in    = last_beam_ff;
      aim_col_in      = aim_col_ff;
      aim_row_in      = aim_row_ff;
      off_screen_in   = off_screen_ff;
      latch_seen_in   = latch_seen_ff;
      bit_counter_in  = bit_counter_ff;
      turbo_prev_in   = turbo_prev_ff;
      turbo_toggle_in = turbo_toggle_ff;
      trigger_hold_in = trigger_hold_ff;
      trigger_bit_in  = trigger_bit_ff;
      pause_hold_in   = pause_hold_ff;
      pause_bit_in    = pause_bit_ff;
      cursor_bit_in   = cursor_bit_ff;
      strobe          = 1'b0;
      serial          = 1'b0;

      unique case (op)
         lgb_pkg::OP_TICK: begin
            // Strobe uses the cursor from before this frame's move
            strobe       = beam_res.strobe;
            last_beam_in = s1_beam_ff;
            if (beam_res.wrap) begin
               aim_col_in    = beam_res.col_wrap;
               aim_row_in    = beam_res.row_wrap;
               off_screen_in = beam_res.off_wrap;
            end
         end
         lgb_pkg::OP_LATCH: begin
            // Restart the report on any latch level change
            if (s1_latch_ff != latch_seen_ff) begin
               latch_seen_in  = s1_latch_ff;
               bit_counter_in = '0;
            end
         end
         lgb_pkg::OP_READ: begin
            // First bit of a report: sample the buttons
            if (bit_counter_ff == lgb_pkg::SLOT_TRIGGER) begin
               if (s1_turbo_ff && !turbo_prev_ff) begin
                  turbo_toggle_in = !turbo_toggle_ff;
               end
               turbo_prev_in = s1_turbo_ff;

               // Trigger: edge sensitive, level sensitive while turbo is on
               trigger_bit_in = 1'b0;
               if (s1_trigger_ff && (turbo_toggle_in || !trigger_hold_ff)) begin
                  trigger_bit_in  = 1'b1;
                  trigger_hold_in = 1'b1;
               end else if (!s1_trigger_ff) begin
                  trigger_hold_in = 1'b0;
               end

               cursor_bit_in = s1_cursor_ff;

               pause_bit_in = 1'b0;
               if (s1_pause_ff && !pause_hold_ff) begin
                  pause_bit_in  = 1'b1;
                  pause_hold_in = 1'b1;
               end else if (!s1_pause_ff) begin
                  pause_hold_in = 1'b0;
               end

               off_screen_in = beam_res.off_now;
            end

            case (bit_counter_ff)
               lgb_pkg::SLOT_TRIGGER:   serial = trigger_bit_in && !off_screen_in;
               lgb_pkg::SLOT_CURSOR:    serial = cursor_bit_in;
               lgb_pkg::SLOT_TURBO:     serial = turbo_toggle_in;
               lgb_pkg::SLOT_PAUSE:     serial = pause_bit_in;
               lgb_pkg::SLOT_OFFSCREEN: serial = off_screen_in;
               // Unused slots read 0, anything past the report reads 1
               default:                 serial = (bit_counter_ff >= lgb_pkg::SLOT_DONE);
            endcase

            if (bit_counter_ff < lgb_pkg::SLOT_DONE) begin
               bit_counter_in = bit_counter_ff + 4'd1;
            end
         end
         default: begin
            // Unused op: hold everything
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_beam_ff    <= '0;
         aim_col_ff      <= '0;
         aim_row_ff      <= '0;
         off_screen_ff   <= 1'b0;
         latch_seen_ff   <= 1'b0;
         bit_counter_ff  <= '0;
         turbo_prev_ff   <= 1'b0;
         turbo_toggle_ff <= 1'b0;
         trigger_hold_ff <= 1'b0;
         trigger_bit_ff  <= 1'b0;
         pause_hold_ff   <= 1'b0;
         pause_bit_ff    <= 1'b0;
         cursor_bit_ff   <= 1'b0;
      end else if (advance && s1_valid_ff) begin
         last_beam_ff    <= last_beam_in;
         aim_col_ff      <= aim_col_in;
         aim_row_ff      <= aim_row_in;
         off_screen_ff   <= off_screen_in;
         latch_seen_ff   <= latch_seen_in;
         bit_counter_ff  <= bit_counter_in;
         turbo_prev_ff   <= turbo_prev_in;
         turbo_toggle_ff <= turbo_toggle_in;
         trigger_hold_ff <= trigger_hold_in;
         trigger_bit_ff  <= trigger_bit_in;
         pause_hold_ff   <= pause_hold_in;
         pause_bit_ff    <= pause_bit_in;
         cursor_bit_ff   <= cursor_bit_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   logic                              rsp_strobe_ff;
   logic                              rsp_serial_ff;
   logic signed [lgb_pkg::AIM_W-1:0]  rsp_aim_x_ff;
   logic signed [lgb_pkg::AIM_W-1:0]  rsp_aim_y_ff;
   logic                              rsp_turbo_ff;

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_strobe_ff <= strobe;
         rsp_serial_ff <= serial;
         rsp_aim_x_ff  <= aim_col_in;
         rsp_aim_y_ff  <= aim_row_in;
         rsp_turbo_ff  <= turbo_toggle_in;
      end
   end

   assign rsp_latch_strobe = rsp_strobe_ff;
   assign rsp_serial_bit   = rsp_serial_ff;
   assign rsp_aim_x        = rsp_aim_x_ff;
   assign rsp_aim_y        = rsp_aim_y_ff;
   assign rsp_turbo_active = rsp_turbo_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
`ifndef SYNTHESIS
   // Report position never runs past the saturation point
   assert property (@(posedge clock) disable iff (reset)
      bit_counter_ff <= lgb_pkg::SLOT_DONE)
      else $error("bit counter beyond saturation");

   // Cursor stays inside the clamp window
   assert property (@(posedge clock) disable iff (reset)
      (aim_col_ff >= -10'sd16) && (aim_col_ff <= 10'sd272) &&
      (aim_row_ff >= -10'sd16) && (aim_row_ff <= 10'sd256))
      else $error("cursor outside clamp window");

   // A strobe comes from a tick, a serial one from a read: never both
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_strobe_ff) |-> !rsp_serial_ff)
      else $error("strobe and serial bit in one transaction");

   // Turbo state moves only when a transaction completes in the result stage
   assert property (@(posedge clock) disable iff (reset)
      !(advance && s1_valid_ff) |=> $stable(turbo_toggle_ff))
      else $error("turbo state changed without a transaction");
`endif

endmodule
